@@ sv/nfh_pkg.sv @@
// ============================================================================
// nfh_pkg: shared types and constants of the newest-first history ring
// Command classes, result status codes, the queued command record and the
// state type of the execution engine.
// ============================================================================
package nfh_pkg;

    // Field widths fixed by the interface
    localparam int KIND_W    = 4;
    localparam int PAYLOAD_W = 64;
    localparam int CNT_W     = 7;
    localparam int TOTAL_W   = 64;
    localparam int STATUS_W  = 2;

    // Command codes on i_command
    localparam logic CMD_EMIT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Event type that means no event
    localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;

    // Reset value of the max kind register
    localparam logic [KIND_W-1:0] MAX_KIND_RESET = 4'd12;

    // Register index of max_event_kind
    localparam logic REG_MAX_KIND = 1'b0;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_READ   = 2'd2;

    // Command class decided by the front end
    typedef enum logic [1:0] {
        CLS_EMIT_OK,
        CLS_EMIT_REJ,
        CLS_READ
    } t_cls;

    // One queued command
    typedef struct packed {
        t_cls                 cls;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [CNT_W-1:0]     want;
    } t_cmd;

    // Execution engine states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

@@ sv/nfh_front.sv @@
// ============================================================================
// nfh_front: command intake and classification
// Holds the max kind register behind the APB port, accepts commands and
// tags each one as accepted emit, rejected emit or read before queueing it.
// ============================================================================
module nfh_front import nfh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Command port
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [KIND_W-1:0]    i_event_kind,
    input  logic [PAYLOAD_W-1:0] i_event_payload,
    input  logic [CNT_W-1:0]     i_read_count,
    // Queue side
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [KIND_W-1:0] r_max_kind;
    logic              w_cfg_wr;
    logic              w_kind_ok;

    // Register write on the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_KIND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kind <= MAX_KIND_RESET;
        end else if (w_cfg_wr) begin
            r_max_kind <= pwdata[KIND_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_KIND) begin
            prdata[KIND_W-1:0] = r_max_kind;
        end
    end

    // Hold off new commands while the queue is full
    assign busy   = i_q_full;
    assign o_push = start && !busy;

    // Classify the command
    assign w_kind_ok = (i_event_kind != KIND_NONE) && (i_event_kind <= r_max_kind);

    always_comb begin
        o_cmd.kind    = i_event_kind;
        o_cmd.payload = i_event_payload;
        o_cmd.want    = i_read_count;
        if (i_command == CMD_READ) begin
            o_cmd.cls = CLS_READ;
        end else if (w_kind_ok) begin
            o_cmd.cls = CLS_EMIT_OK;
        end else begin
            o_cmd.cls = CLS_EMIT_REJ;
        end
    end

endmodule

@@ sv/nfh_cmd_queue.sv @@
// ============================================================================
// nfh_cmd_queue: two-entry command queue
// Decouples command intake from execution so either side can stall alone.
// ============================================================================
module nfh_cmd_queue import nfh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/nfh_back.sv @@
// ============================================================================
// nfh_back: history ring execution engine
// Owns the ring memory, write pointer, emit total and full flag; writes
// accepted emits and streams read results newest first, one per cycle.
// ============================================================================
module nfh_back import nfh_pkg::*; #(
    parameter int RING_DEPTH    = 64,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Queue side
    input  logic                  i_q_empty,
    input  t_cmd                  i_q_head,
    output logic                  o_pop,
    // Results
    output logic                  o_strobe,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_entry_valid,
    output logic [KIND_W-1:0]     o_out_kind,
    output logic [PAYLOAD_W-1:0]  o_out_payload,
    output logic [CNT_W-1:0]      o_entries_returned,
    output logic [TOTAL_W-1:0]    o_total_emitted,
    output logic                  o_last
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);

    // Ring storage
    logic [KIND_W-1:0]        kind_mem    [RING_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] payload_mem [RING_DEPTH];
    logic [KIND_W-1:0]        r_mem_kind;
    logic [PAYLOAD_WIDTH-1:0] r_mem_payload;

    // Control state
    t_back_state      r_state;
    t_back_state      n_state;
    logic [AW-1:0]    r_wp;
    logic [TOTAL_W-1:0] r_total;
    logic             r_full;
    logic [AW-1:0]    r_addr;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] r_n;

    // Result registers
    logic                r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic                r_entry_valid;
    logic [CNT_W-1:0]    r_ret;
    logic                r_last;

    logic             w_pop;
    logic             w_wr_en;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_prev_wp;
    logic [AW-1:0]    w_prev_addr;
    logic [CNT_W-1:0] w_valid_cnt;
    logic [CNT_W-1:0] w_n;

    // Entry count available and capped read length
    assign w_valid_cnt = r_full ? CNT_W'(RING_DEPTH) : CNT_W'(r_total[AW-1:0]);
    assign w_n         = (i_q_head.want < w_valid_cnt) ? i_q_head.want : w_valid_cnt;
    assign w_prev_wp   = (r_wp == '0) ? PTR_LAST : r_wp - AW'(1);
    assign w_prev_addr = (r_addr == '0) ? PTR_LAST : r_addr - AW'(1);
    assign w_pop       = (r_state == BK_IDLE) && !i_q_empty;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_pop && i_q_head.cls == CLS_READ && w_n > CNT_W'(1)) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (r_remain == CNT_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Memory and queue controls
    always_comb begin
        o_pop     = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = w_prev_wp;
        case (r_state)
            BK_IDLE: begin
                o_pop = w_pop;
                if (w_pop) begin
                    case (i_q_head.cls)
                        CLS_EMIT_OK: w_wr_en = 1'b1;
                        CLS_READ:    w_rd_en = (w_n != '0);
                        default:     w_wr_en = 1'b0;
                    endcase
                end
            end
            BK_READ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_prev_addr;
            end
            default: o_pop = 1'b0;
        endcase
    end

    // Ring write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            kind_mem[r_wp]    <= i_q_head.kind;
            payload_mem[r_wp] <= i_q_head.payload[PAYLOAD_WIDTH-1:0];
        end
        if (w_rd_en) begin
            r_mem_kind    <= kind_mem[w_rd_addr];
            r_mem_payload <= payload_mem[w_rd_addr];
        end
    end

    // Advance ring state and build results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_wp          <= '0;
            r_total       <= '0;
            r_full        <= 1'b0;
            r_strobe      <= 1'b0;
            r_entry_valid <= 1'b0;
            r_addr        <= '0;
            r_remain      <= '0;
            r_n           <= '0;
            r_status      <= STATUS_ACCEPT;
            r_ret         <= '0;
            r_last        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_pop || (r_state == BK_READ);
            if (w_pop) begin
                case (i_q_head.cls)
                    CLS_EMIT_OK: begin
                        r_status      <= STATUS_ACCEPT;
                        r_entry_valid <= 1'b0;
                        r_ret         <= '0;
                        r_last        <= 1'b1;
                        r_wp          <= (r_wp == PTR_LAST) ? '0 : r_wp + AW'(1);
                        r_total       <= r_total + TOTAL_W'(1);
                        if (r_wp == PTR_LAST) begin
                            r_full <= 1'b1;
                        end
                    end
                    CLS_READ: begin
                        r_status      <= STATUS_READ;
                        r_entry_valid <= (w_n != '0);
                        r_ret         <= w_n;
                        r_last        <= (w_n <= CNT_W'(1));
                        r_addr        <= w_prev_wp;
                        r_remain      <= w_n - CNT_W'(1);
                        r_n           <= w_n;
                    end
                    default: begin
                        r_status      <= STATUS_REJECT;
                        r_entry_valid <= 1'b0;
                        r_ret         <= '0;
                        r_last        <= 1'b1;
                    end
                endcase
            end else if (r_state == BK_READ) begin
                r_status      <= STATUS_READ;
                r_entry_valid <= 1'b1;
                r_ret         <= r_n;
                r_last        <= (r_remain == CNT_W'(1));
                r_addr        <= w_prev_addr;
                r_remain      <= r_remain - CNT_W'(1);
            end
        end
    end

    // Drive result ports; entry fields read zero unless an entry is carried
    assign o_strobe           = r_strobe;
    assign o_status           = r_status;
    assign o_entry_valid      = r_entry_valid;
    assign o_out_kind         = r_entry_valid ? r_mem_kind : '0;
    assign o_out_payload      = r_entry_valid ? PAYLOAD_W'(r_mem_payload) : '0;
    assign o_entries_returned = r_ret;
    assign o_total_emitted    = r_total;
    assign o_last             = r_last;

    // Entry results only come from reads
    a_entry_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_entry_valid |-> r_status == STATUS_READ)
        else $error("entry result with non-read status");

    // Streaming a read yields a result the next cycle
    a_read_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_READ |=> r_strobe && r_entry_valid)
        else $error("read stream dropped a result");

    // No new command is taken while a read streams
    a_no_pop_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_READ |-> !o_pop)
        else $error("pop during read stream");

    // Before the ring fills, the pointer tracks the emit total
    a_ptr_tracks_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> r_wp == r_total[AW-1:0])
        else $error("write pointer out of step with total");

    // Every read result reports a length no larger than the ring
    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_ret <= CNT_W'(RING_DEPTH))
        else $error("read length exceeds ring depth");

endmodule

@@ sv/newest_first_history_ring.sv @@
// ============================================================================
// newest_first_history_ring: lossy event history ring, newest first reads
// Top level: command intake, two-entry command queue, execution engine.
// ============================================================================
// A command is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. When the engine is free, an
// accepted command passes through a queue slot and then the result
// registers before its first result is on o_strobe. An emit
// (accepted or rejected) gives one result; a read of n entries gives
// max(n, 1) results, one result per cycle, and the engine takes no new
// command while a read streams. Results cannot be held off by the
// receiver. Mixed traffic sustains about one command per cycle for
// emits.
module newest_first_history_ring import nfh_pkg::*; #(
    parameter int RING_DEPTH    = 64,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Command port
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [KIND_W-1:0]    i_event_kind,
    input  logic [PAYLOAD_W-1:0] i_event_payload,
    input  logic [CNT_W-1:0]     i_read_count,
    // Result port
    output logic                 o_strobe,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_entry_valid,
    output logic [KIND_W-1:0]    o_out_kind,
    output logic [PAYLOAD_W-1:0] o_out_payload,
    output logic [CNT_W-1:0]     o_entries_returned,
    output logic [TOTAL_W-1:0]   o_total_emitted,
    output logic                 o_last
);

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    // Intake and classification
    nfh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_event_kind    (i_event_kind),
        .i_event_payload (i_event_payload),
        .i_read_count    (i_read_count),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    // Command queue
    nfh_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head_cmd)
    );

    // Ring execution
    nfh_back #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (w_q_empty),
        .i_q_head           (w_head_cmd),
        .o_pop              (w_pop),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_entry_valid      (o_entry_valid),
        .o_out_kind         (o_out_kind),
        .o_out_payload      (o_out_payload),
        .o_entries_returned (o_entries_returned),
        .o_total_emitted    (o_total_emitted),
        .o_last             (o_last)
    );

endmodule

@@ tb/sv/tb_newest_first_history_ring.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_newest_first_history_ring: self-checking bench for the history ring
// Drives emit and read commands through the start/busy port and programs
// max_event_kind over APB between phases. A scoreboard class keeps its own
// copy of the ring, predicts every result and checks each strobed result
// in order. Directed corner cases come first, then random mixed traffic.
// ============================================================================

localparam int HIST_DEPTH   = 64;
localparam int HIST_PAYLOAD = 64;
localparam int STALL_LIMIT  = 1000;

typedef struct packed {
    logic [nfh_pkg::STATUS_W-1:0]  status;
    logic                          entry_valid;
    logic [nfh_pkg::KIND_W-1:0]    kind;
    logic [nfh_pkg::PAYLOAD_W-1:0] payload;
    logic [nfh_pkg::CNT_W-1:0]     returned;
    logic [nfh_pkg::TOTAL_W-1:0]   total;
    logic                          last;
} t_ring_result;

// Shadow ring plus the queue of results still owed by the block
class ring_history_checker;
    logic [nfh_pkg::KIND_W-1:0]    max_kind;
    logic [nfh_pkg::KIND_W-1:0]    kind_mem [HIST_DEPTH];
    logic [nfh_pkg::PAYLOAD_W-1:0] payload_mem [HIST_DEPTH];
    int unsigned                   wr_ptr;
    logic [nfh_pkg::TOTAL_W-1:0]   emit_total;
    bit                            ring_full;
    t_ring_result                  owed_results [$];
    int                            errors;

    function new();
        max_kind   = nfh_pkg::MAX_KIND_RESET;
        wr_ptr     = 0;
        emit_total = '0;
        ring_full  = 0;
        errors     = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    function void owe(logic [1:0] status, logic valid, logic [3:0] kind,
                      logic [63:0] payload, logic [6:0] returned, logic last);
        t_ring_result r;
        r.status      = status;
        r.entry_valid = valid;
        r.kind        = kind;
        r.payload     = payload;
        r.returned    = returned;
        r.total       = emit_total;
        r.last        = last;
        owed_results.push_back(r);
    endfunction

    // Predict the results of one accepted command
    function void note_command(logic cmd, logic [3:0] kind, logic [63:0] payload,
                               logic [6:0] want);
        int unsigned live;
        int unsigned n;
        int unsigned idx;
        if (cmd == nfh_pkg::CMD_EMIT) begin
            if (kind == nfh_pkg::KIND_NONE || kind > max_kind) begin
                owe(nfh_pkg::STATUS_REJECT, 1'b0, '0, '0, '0, 1'b1);
            end else begin
                kind_mem[wr_ptr]    = kind;
                payload_mem[wr_ptr] = payload;
                wr_ptr              = (wr_ptr + 1) % HIST_DEPTH;
                emit_total          = emit_total + 1;
                if (emit_total >= HIST_DEPTH) ring_full = 1;
                owe(nfh_pkg::STATUS_ACCEPT, 1'b0, '0, '0, '0, 1'b1);
            end
        end else begin
            if (ring_full || emit_total >= HIST_DEPTH) live = HIST_DEPTH;
            else live = int'(emit_total);
            n = (want < live) ? want : live;
            if (n == 0) begin
                owe(nfh_pkg::STATUS_READ, 1'b0, '0, '0, '0, 1'b1);
            end else begin
                // walk back from the newest entry
                idx = wr_ptr;
                for (int i = 0; i < n; i++) begin
                    idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
                    owe(nfh_pkg::STATUS_READ, 1'b1, kind_mem[idx], payload_mem[idx],
                        7'(n), (i == n - 1));
                end
            end
        end
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    // Check one strobed result against the oldest prediction
    function void check_result(t_ring_result got);
        t_ring_result exp_r;
        if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp_r = owed_results.pop_front();
        compare_field("status", exp_r.status, got.status);
        compare_field("entry_valid", exp_r.entry_valid, got.entry_valid);
        compare_field("out_kind", exp_r.kind, got.kind);
        compare_field("out_payload", exp_r.payload, got.payload);
        compare_field("entries_returned", exp_r.returned, got.returned);
        compare_field("total_emitted", exp_r.total, got.total);
        compare_field("last", exp_r.last, got.last);
    endfunction
endclass

module tb_newest_first_history_ring;
    import nfh_pkg::*;

    localparam logic [2:0] MAX_KIND_ADDR = {REG_MAX_KIND, 2'b00};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [KIND_W-1:0]    i_event_kind;
    logic [PAYLOAD_W-1:0] i_event_payload;
    logic [CNT_W-1:0]     i_read_count;
    logic                 o_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_entry_valid;
    logic [KIND_W-1:0]    o_out_kind;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic [CNT_W-1:0]     o_entries_returned;
    logic [TOTAL_W-1:0]   o_total_emitted;
    logic                 o_last;

    ring_history_checker sb;
    bit                  no_idle;
    int                  quiet_cycles;

    newest_first_history_ring #(
        .RING_DEPTH    (HIST_DEPTH),
        .PAYLOAD_WIDTH (HIST_PAYLOAD)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_event_kind       (i_event_kind),
        .i_event_payload    (i_event_payload),
        .i_read_count       (i_read_count),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_entry_valid      (o_entry_valid),
        .o_out_kind         (o_out_kind),
        .o_out_payload      (o_out_payload),
        .o_entries_returned (o_entries_returned),
        .o_total_emitted    (o_total_emitted),
        .o_last             (o_last)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result({o_status, o_entry_valid, o_out_kind, o_out_payload,
                             o_entries_returned, o_total_emitted, o_last});
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[newest_first_history_ring] ERROR");
            $finish;
        end
    end

    // Present one command, idling at random first, and hold it until taken
    task automatic send_command(input logic cmd, input logic [3:0] kind,
                                input logic [63:0] payload, input logic [6:0] want);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 22) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_event_kind    <= kind;
        i_event_payload <= payload;
        i_read_count    <= want;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, kind, payload, want);
    endtask

    // Drop start and wait until every owed result has arrived
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write max_event_kind, then read it back
    task automatic program_max_kind(input logic [3:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_KIND_ADDR;
        pwdata  <= {28'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.max_kind = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.compare_field("max_event_kind", {60'd0, value}, {32'd0, prdata});
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly valid emits with reads of mixed depth in between
    task automatic random_items(input int count);
        logic [3:0]  kind;
        logic [63:0] payload;
        logic [6:0]  want;
        int          roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 72) begin
                if (sb.max_kind == KIND_NONE || $urandom_range(99) < 20) begin
                    kind = 4'($urandom_range(15));
                end else begin
                    kind = 4'($urandom_range(sb.max_kind, 1));
                end
                roll = $urandom_range(99);
                if (roll < 5) payload = '0;
                else if (roll < 10) payload = '1;
                else payload = {$urandom, $urandom};
                send_command(CMD_EMIT, kind, payload, 7'($urandom_range(127)));
            end else begin
                roll = $urandom_range(99);
                if (roll < 15) want = '0;
                else if (roll < 75) want = 7'($urandom_range(8, 1));
                else if (roll < 90) want = 7'($urandom_range(64, 9));
                else want = 7'($urandom_range(127, 65));
                send_command(CMD_READ, 4'($urandom_range(15)), {$urandom, $urandom}, want);
            end
        end
    endtask

    initial begin
        sb              = new();
        no_idle         = 0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        i_command       = CMD_EMIT;
        i_event_kind    = KIND_NONE;
        i_event_payload = '0;
        i_read_count    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty ring, rejects, capping, reset limit of 12
        send_command(CMD_READ, KIND_NONE, '0, 7'd0);
        send_command(CMD_READ, KIND_NONE, '0, 7'd5);
        send_command(CMD_EMIT, KIND_NONE, 64'h0123_4567_89AB_CDEF, 7'd0);
        send_command(CMD_EMIT, 4'd13, '1, 7'd0);
        send_command(CMD_EMIT, 4'd15, '1, 7'd127);
        send_command(CMD_EMIT, 4'd12, '1, 7'd0);
        send_command(CMD_EMIT, 4'd1, '0, 7'd0);
        send_command(CMD_READ, 4'd15, '1, 7'd0);
        send_command(CMD_READ, KIND_NONE, '0, 7'd1);
        send_command(CMD_READ, KIND_NONE, '0, 7'd2);
        send_command(CMD_READ, KIND_NONE, '0, 7'd127);
        send_command(CMD_EMIT, 4'd5, 64'hA5A5_5A5A_F00F_0FF0, 7'd0);
        send_command(CMD_READ, KIND_NONE, '0, 7'd64);
        send_command(CMD_READ, KIND_NONE, '0, 7'd3);
        drain();

        // Widest limit: every type but zero goes in
        program_max_kind(4'd15);
        send_command(CMD_EMIT, 4'd15, 64'h8000_0000_0000_0001, 7'd0);
        send_command(CMD_EMIT, 4'd14, 64'h7FFF_FFFF_FFFF_FFFE, 7'd0);
        send_command(CMD_READ, KIND_NONE, '0, 7'd65);
        no_idle = 1;
        random_items(30);
        no_idle = 0;
        random_items(30);
        drain();

        // Zero limit rejects every emit
        program_max_kind(4'd0);
        random_items(12);
        drain();

        program_max_kind(4'd1);
        random_items(12);
        drain();

        program_max_kind(4'($urandom_range(14, 2)));
        random_items(36);
        send_command(CMD_READ, KIND_NONE, '0, 7'd127);
        send_command(CMD_READ, KIND_NONE, '0, 7'd64);
        drain();

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[newest_first_history_ring] OK");
        end else begin
            $display("[newest_first_history_ring] ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/nfh_pkg.sv
sv/nfh_front.sv
sv/nfh_cmd_queue.sv
sv/nfh_back.sv
sv/newest_first_history_ring.sv
tb/sv/tb_newest_first_history_ring.sv
